[src/pfc_pkg.sv]
// shared types, format codes and expansion tables for the pixel format converter
`default_nettype none
package pfc_pkg;

  typedef enum logic [2:0] {
    FMT_ARGB4444 = 3'd0,
    FMT_RGBA4444 = 3'd1,
    FMT_RGB565   = 3'd2,
    FMT_RGB      = 3'd3,
    FMT_RGBA     = 3'd4,
    FMT_ARGB     = 3'd5
  } fmt_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_FORMAT = 2'd1;

  localparam int unsigned PROD_W = 14;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } chan_t;

  typedef struct packed {
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] g;
    logic [PROD_W-1:0] b;
    logic [PROD_W-1:0] a;
  } prod_t;

  typedef struct packed {
    logic        bypass;
    logic [31:0] word;
  } byp_t;

  typedef logic [31:0][7:0] w5_tab_t;
  typedef logic [63:0][7:0] w6_tab_t;

  function automatic w5_tab_t build_w5();
    w5_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic w6_tab_t build_w6();
    w6_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam w5_tab_t W5_TAB = build_w5();
  localparam w6_tab_t W6_TAB = build_w6();

  function automatic logic fmt_ok(logic [2:0] f);
    return f <= FMT_ARGB;
  endfunction

endpackage
`default_nettype wire

[src/pfc_unpack.sv]
// first stage: expands the source pixel to four 8-bit channels or prepares a bypass word
`default_nettype none
module pfc_unpack
  import pfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire logic [31:0] pixel,
  input  wire logic [2:0]  src_fmt,
  input  wire logic [2:0]  dst_fmt,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output chan_t            chan,
  output byp_t             byp
);

  logic  valid_r;
  chan_t chan_r, chan_nxt;
  byp_t  byp_r, byp_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign chan     = chan_r;
  assign byp      = byp_r;

  always_comb begin
    chan_nxt = '0;
    unique case (src_fmt)
      FMT_ARGB4444: begin
        chan_nxt.a = {pixel[15:12], pixel[15:12]};
        chan_nxt.r = {pixel[11:8], pixel[11:8]};
        chan_nxt.g = {pixel[7:4], pixel[7:4]};
        chan_nxt.b = {pixel[3:0], pixel[3:0]};
      end
      FMT_RGBA4444: begin
        chan_nxt.r = {pixel[15:12], pixel[15:12]};
        chan_nxt.g = {pixel[11:8], pixel[11:8]};
        chan_nxt.b = {pixel[7:4], pixel[7:4]};
        chan_nxt.a = {pixel[3:0], pixel[3:0]};
      end
      FMT_RGB565: begin
        chan_nxt.r = W5_TAB[pixel[15:11]];
        chan_nxt.g = W6_TAB[pixel[10:5]];
        chan_nxt.b = W5_TAB[pixel[4:0]];
        chan_nxt.a = 8'hff;
      end
      FMT_RGB: begin
        chan_nxt.r = pixel[7:0];
        chan_nxt.g = pixel[15:8];
        chan_nxt.b = pixel[23:16];
        chan_nxt.a = 8'hff;
      end
      FMT_RGBA: begin
        chan_nxt.r = pixel[7:0];
        chan_nxt.g = pixel[15:8];
        chan_nxt.b = pixel[23:16];
        chan_nxt.a = pixel[31:24];
      end
      FMT_ARGB: begin
        chan_nxt.a = pixel[7:0];
        chan_nxt.r = pixel[15:8];
        chan_nxt.g = pixel[23:16];
        chan_nxt.b = pixel[31:24];
      end
      default: chan_nxt = '0;
    endcase
  end

  always_comb begin
    byp_nxt = '0;
    if (!fmt_ok(src_fmt) || !fmt_ok(dst_fmt)) begin
      byp_nxt.bypass = 1'b1;
    end else if (src_fmt == dst_fmt) begin
      byp_nxt.bypass = 1'b1;
      if (src_fmt <= FMT_RGB565) begin
        byp_nxt.word = {16'h0, pixel[15:0]};
      end else if (src_fmt == FMT_RGB) begin
        byp_nxt.word = {8'h0, pixel[23:0]};
      end else begin
        byp_nxt.word = pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      chan_r <= chan_nxt;
      byp_r  <= byp_nxt;
    end
  end

endmodule
`default_nettype wire

[src/pfc_scale.sv]
// second stage: each channel times top code of its dest field, if under 8 bits
`default_nettype none
module pfc_scale
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire chan_t      chan,
  input  wire byp_t       byp_in,
  input  wire logic [2:0] dst_fmt,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output prod_t           prod,
  output byp_t            byp
);

  logic        valid_r;
  prod_t       prod_r, prod_nxt;
  byp_t        byp_r;
  logic [5:0]  top_r4, top_g4, top_b4, top_a4;
  logic        wide_fmt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign prod     = prod_r;
  assign byp      = byp_r;

  always_comb begin
    wide_fmt = 1'b0;
    top_r4   = 6'd0;
    top_g4   = 6'd0;
    top_b4   = 6'd0;
    top_a4   = 6'd0;
    unique case (dst_fmt)
      FMT_ARGB4444, FMT_RGBA4444: begin
        top_r4 = 6'd15;
        top_g4 = 6'd15;
        top_b4 = 6'd15;
        top_a4 = 6'd15;
      end
      FMT_RGB565: begin
        top_r4 = 6'd31;
        top_g4 = 6'd63;
        top_b4 = 6'd31;
      end
      default: wide_fmt = 1'b1;
    endcase
  end

  always_comb begin
    if (wide_fmt) begin
      prod_nxt.r = PROD_W'(chan.r);
      prod_nxt.g = PROD_W'(chan.g);
      prod_nxt.b = PROD_W'(chan.b);
      prod_nxt.a = PROD_W'(chan.a);
    end else begin
      prod_nxt.r = PROD_W'(chan.r) * PROD_W'(top_r4);
      prod_nxt.g = PROD_W'(chan.g) * PROD_W'(top_g4);
      prod_nxt.b = PROD_W'(chan.b) * PROD_W'(top_b4);
      prod_nxt.a = PROD_W'(chan.a) * PROD_W'(top_a4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r <= prod_nxt;
      byp_r  <= byp_in;
    end
  end

endmodule
`default_nettype wire

[src/pfc_pack.sv]
// third stage: 16-bit formats divide by 255; packs dst word into the output register
`default_nettype none
module pfc_pack
  import pfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire prod_t       prod,
  input  wire byp_t        byp,
  input  wire logic [2:0]  dst_fmt,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output logic [31:0]      pixel
);

  logic        valid_r;
  logic [31:0] pixel_r, pixel_nxt;
  logic [6:0]  qr, qg, qb, qa;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign pixel    = pixel_r;

  function automatic logic [6:0] div255(logic [PROD_W-1:0] x);
    logic [PROD_W:0] s;
    s = (PROD_W+1)'(x) + (PROD_W+1)'(1) + (PROD_W+1)'(x[PROD_W-1:8]);
    return s[PROD_W:8];
  endfunction

  assign qr = div255(prod.r);
  assign qg = div255(prod.g);
  assign qb = div255(prod.b);
  assign qa = div255(prod.a);

  always_comb begin
    pixel_nxt = '0;
    if (byp.bypass) begin
      pixel_nxt = byp.word;
    end else begin
      unique case (dst_fmt)
        FMT_ARGB4444: pixel_nxt = {16'h0, qa[3:0], qr[3:0], qg[3:0], qb[3:0]};
        FMT_RGBA4444: pixel_nxt = {16'h0, qr[3:0], qg[3:0], qb[3:0], qa[3:0]};
        FMT_RGB565:   pixel_nxt = {16'h0, qr[4:0], qg[5:0], qb[4:0]};
        FMT_RGB:      pixel_nxt = {8'h0, prod.b[7:0], prod.g[7:0], prod.r[7:0]};
        FMT_RGBA:     pixel_nxt = {prod.a[7:0], prod.b[7:0], prod.g[7:0], prod.r[7:0]};
        FMT_ARGB:     pixel_nxt = {prod.b[7:0], prod.g[7:0], prod.r[7:0], prod.a[7:0]};
        default:      pixel_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pixel_r <= pixel_nxt;
    end
  end

endmodule
`default_nettype wire

[src/pixel_format_converter.sv]
// pixel format converter top level: format registers and three-stage pipeline
//
// Converts packed pixels between ARGB4444, RGBA4444, RGB565, RGB, RGBA and
// ARGB (codes 0 to 5 in src_format and dst_format, written through the cfg port
// at index 0 and 1). Throughput is one pixel per cycle while out_ready does not
// stall the output; a request passes three register stages: unpack with table
// expansion, channel scaling by one small multiplier per channel, and the
// reciprocal divide by 255 with packing into the output register. Each stage
// holds its item on a stall and frees itself when the next one takes it, so a
// waiting result never blocks new requests while bubbles remain. Equal formats
// pass the pixel through at its own width; a code of 6 or 7 yields zero. Change
// the formats only while no request is in flight.
`default_nettype none
module pixel_format_converter
  import pfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          in_src_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_dst_pixel,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [2:0]           cfg_data
);

  logic [2:0] src_fmt_r;
  logic [2:0] dst_fmt_r;

  logic  s1_valid, s1_ready;
  chan_t s1_chan;
  byp_t  s1_byp;
  logic  s2_valid, s2_ready;
  prod_t s2_prod;
  byp_t  s2_byp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= FMT_RGBA;
      dst_fmt_r <= FMT_RGBA;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SRC_FORMAT) begin
        src_fmt_r <= cfg_data;
      end else if (cfg_index == REG_DST_FORMAT) begin
        dst_fmt_r <= cfg_data;
      end
    end
  end

  pfc_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .pixel    (in_src_pixel),
    .src_fmt  (src_fmt_r),
    .dst_fmt  (dst_fmt_r),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .chan     (s1_chan),
    .byp      (s1_byp)
  );

  pfc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .chan     (s1_chan),
    .byp_in   (s1_byp),
    .dst_fmt  (dst_fmt_r),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .prod     (s2_prod),
    .byp      (s2_byp)
  );

  pfc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .prod     (s2_prod),
    .byp      (s2_byp),
    .dst_fmt  (dst_fmt_r),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .pixel    (out_dst_pixel)
  );

`ifndef SYNTHESIS
  // an empty first stage always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty first stage");

  // unknown format codes give a zero result
  a_bad_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (src_fmt_r > FMT_ARGB || dst_fmt_r > FMT_ARGB)) |-> out_dst_pixel == 32'h0)
    else $error("nonzero result for unknown format");

  // 16-bit destinations leave the upper half clear
  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && dst_fmt_r <= FMT_RGB565) |-> out_dst_pixel[31:16] == 16'h0)
    else $error("upper half set for 16-bit destination");

  // 24-bit destination leaves the top byte clear
  a_rgb_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && dst_fmt_r == FMT_RGB) |-> out_dst_pixel[31:24] == 8'h0)
    else $error("top byte set for 24-bit destination");
`endif

endmodule
`default_nettype wire
